>>> rtl/core/tws_pkg.sv
// Shared constants, field widths and control structs of the stereo table waveshaper.
// Used by tws_front, tws_back and table_waveshaper_stereo_unit; depends on nothing.
package tws_pkg;

    // Curve table size and the address width that follows from it.
    localparam int CURVE_POINTS = 200;
    localparam int ADDR_W       = $clog2(CURVE_POINTS);

    // Field widths of the streams and the configuration port.
    localparam int S_W       = 24;
    localparam int T_W       = 16;
    localparam int CFG_W     = 16;
    localparam int ENTRY_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;

    // Fixed-point scaling.
    localparam int FRAC_W    = 20;
    localparam int GAIN_SH   = 12;
    localparam int GAIN_HALF = 1 << (GAIN_SH - 1);
    localparam int LVL_SH    = 15;
    localparam int LVL_HALF  = 1 << (LVL_SH - 1);
    localparam int CLIP_ONE  = 1 << FRAC_W;
    localparam int SAT_MAX   = (2 ** (S_W - 1)) - 1;
    localparam int SAT_MIN   = -(2 ** (S_W - 1));

    // Datapath widths, sized for the worst case of every stage.
    localparam int PG_W  = S_W + CFG_W + 1;
    localparam int GR_W  = 29;
    localparam int M_W   = 27;
    localparam int P_W   = M_W + $clog2(CURVE_POINTS + 1);
    localparam int IDX_W = P_W - FRAC_W;
    localparam int OP_W  = M_W + 1;
    localparam int X_W   = OP_W + T_W + 1;
    localparam int Y_W   = 29;
    localparam int WP_W  = Y_W + CFG_W + 1;
    localparam int W_W   = 34;
    localparam int PW_W  = W_W + CFG_W + 1;
    localparam int PD_W  = S_W + CFG_W + 1;
    localparam int MIX_W = PW_W + 1;

    // Request kinds carried in tuser.
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_LEVEL   = 3'd4;

    typedef struct packed {
        logic [CFG_W-1:0] input_gain;
        logic [CFG_W-1:0] output_gain;
        logic             clip_enable;
        logic [CFG_W-1:0] wet_level;
        logic [CFG_W-1:0] dry_level;
    } tws_cfg_t;

    // Load enables of the eleven pipeline stages.
    typedef struct packed {
        logic p1;
        logic p2;
        logic p3;
        logic p4;
        logic p5;
        logic p6;
        logic p7;
        logic p8;
        logic p9;
        logic p10;
        logic p11;
    } tws_en_t;

    // Per-channel values handed from the front half to the back half.
    typedef struct packed {
        logic signed [S_W-1:0] s;
        logic [M_W-1:0]        m;
        logic [FRAC_W-1:0]     f;
        logic                  over;
        logic                  neg;
    } tws_fr_t;

endpackage

>>> rtl/core/tws_front.sv
// Front half of one waveshaper channel: input gain, clip, magnitude and table address.
// Depends on tws_pkg.
module tws_front (
    input  logic                               clk,
    input  tws_pkg::tws_en_t                   en,
    input  tws_pkg::tws_cfg_t                  cfg,
    input  logic signed [tws_pkg::S_W-1:0]     s_in,
    output tws_pkg::tws_fr_t                   fr,
    output logic [tws_pkg::ADDR_W-1:0]         addr
);

    logic signed [tws_pkg::CFG_W:0]    gain_s;
    logic signed [tws_pkg::PG_W-1:0]   prod_next;
    logic signed [tws_pkg::PG_W-1:0]   prod_reg;
    logic signed [tws_pkg::S_W-1:0]    s2_reg;

    logic signed [tws_pkg::PG_W-1:0]   g_rnd;
    logic signed [tws_pkg::PG_W-1:0]   g_full;
    logic signed [tws_pkg::GR_W-1:0]   g;
    logic signed [tws_pkg::GR_W-1:0]   one_p;
    logic signed [tws_pkg::GR_W-1:0]   one_n;
    logic signed [tws_pkg::GR_W-1:0]   gc;
    logic signed [tws_pkg::GR_W-1:0]   mag;
    logic [tws_pkg::M_W-1:0]           m_next;
    logic                              neg_next;
    logic [tws_pkg::M_W-1:0]           m3_reg;
    logic                              neg3_reg;
    logic signed [tws_pkg::S_W-1:0]    s3_reg;

    logic [tws_pkg::P_W-1:0]           p_full;
    logic [tws_pkg::IDX_W-1:0]         idx;
    logic                              over_next;
    logic [tws_pkg::ADDR_W-1:0]        addr_next;
    logic [tws_pkg::ADDR_W-1:0]        addr4_reg;
    logic [tws_pkg::FRAC_W-1:0]        f4_reg;
    logic [tws_pkg::M_W-1:0]           m4_reg;
    logic                              over4_reg;
    logic                              neg4_reg;
    logic signed [tws_pkg::S_W-1:0]    s4_reg;

    // Stage 2: sample times input gain.
    assign gain_s    = $signed({1'b0, cfg.input_gain});
    assign prod_next = tws_pkg::PG_W'(s_in) * tws_pkg::PG_W'(gain_s);

    always_ff @(posedge clk)
    begin
        if (en.p2)
        begin
            prod_reg <= prod_next;
            s2_reg   <= s_in;
        end
    end

    // Stage 3: round back to Q.20, clamp if enabled, split sign and magnitude.
    assign g_rnd  = prod_reg + tws_pkg::PG_W'(tws_pkg::GAIN_HALF);
    assign g_full = g_rnd >>> tws_pkg::GAIN_SH;
    assign g      = g_full[tws_pkg::GR_W-1:0];
    assign one_p  = tws_pkg::GR_W'(tws_pkg::CLIP_ONE);
    assign one_n  = -one_p;

    always_comb
    begin
        gc = g;
        if (cfg.clip_enable && (g > one_p))
        begin
            gc = one_p;
        end
        else if (cfg.clip_enable && (g < one_n))
        begin
            gc = one_n;
        end
        neg_next = gc[tws_pkg::GR_W-1];
        mag      = neg_next ? -gc : gc;
        m_next   = mag[tws_pkg::M_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.p3)
        begin
            m3_reg   <= m_next;
            neg3_reg <= neg_next;
            s3_reg   <= s2_reg;
        end
    end

    // Stage 4: magnitude times the table size gives index and fraction.
    assign p_full    = tws_pkg::P_W'(m3_reg) * tws_pkg::P_W'(tws_pkg::CURVE_POINTS);
    assign idx       = p_full[tws_pkg::P_W-1:tws_pkg::FRAC_W];
    assign over_next = (idx >= tws_pkg::IDX_W'(tws_pkg::CURVE_POINTS));
    assign addr_next = over_next ? tws_pkg::ADDR_W'(tws_pkg::CURVE_POINTS - 1)
                                 : idx[tws_pkg::ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en.p4)
        begin
            addr4_reg <= addr_next;
            f4_reg    <= p_full[tws_pkg::FRAC_W-1:0];
            m4_reg    <= m3_reg;
            over4_reg <= over_next;
            neg4_reg  <= neg3_reg;
            s4_reg    <= s3_reg;
        end
    end

    assign addr    = addr4_reg;
    assign fr.s    = s4_reg;
    assign fr.m    = m4_reg;
    assign fr.f    = f4_reg;
    assign fr.over = over4_reg;
    assign fr.neg  = neg4_reg;

endmodule

>>> rtl/core/tws_back.sv
// Back half of one waveshaper channel: interpolation, sign, output gain and wet/dry mix.
// Depends on tws_pkg; the table entries arrive from the memory stage of the top level.
module tws_back (
    input  logic                               clk,
    input  tws_pkg::tws_en_t                   en,
    input  tws_pkg::tws_cfg_t                  cfg,
    input  tws_pkg::tws_fr_t                   fr,
    input  logic signed [tws_pkg::T_W-1:0]     tbl_a,
    input  logic signed [tws_pkg::T_W-1:0]     tbl_b,
    output logic signed [tws_pkg::S_W-1:0]     res
);

    logic signed [tws_pkg::S_W-1:0]    s5_reg;
    logic [tws_pkg::M_W-1:0]           m5_reg;
    logic [tws_pkg::FRAC_W-1:0]        f5_reg;
    logic                              over5_reg;
    logic                              neg5_reg;

    logic signed [tws_pkg::T_W:0]      diff;
    logic signed [tws_pkg::OP_W-1:0]   op1;
    logic signed [tws_pkg::T_W:0]      op2;
    logic signed [tws_pkg::X_W-1:0]    mprod_next;
    logic signed [tws_pkg::X_W-1:0]    madd_next;
    logic signed [tws_pkg::X_W-1:0]    mprod_reg;
    logic signed [tws_pkg::X_W-1:0]    madd_reg;
    logic                              neg6_reg;
    logic signed [tws_pkg::S_W-1:0]    s6_reg;

    logic signed [tws_pkg::X_W-1:0]    x_rnd;
    logic signed [tws_pkg::X_W-1:0]    x_full;
    logic signed [tws_pkg::Y_W-1:0]    r;
    logic signed [tws_pkg::Y_W-1:0]    y_next;
    logic signed [tws_pkg::Y_W-1:0]    y7_reg;
    logic signed [tws_pkg::S_W-1:0]    s7_reg;

    logic signed [tws_pkg::CFG_W:0]    og_s;
    logic signed [tws_pkg::WP_W-1:0]   wp_next;
    logic signed [tws_pkg::WP_W-1:0]   wp8_reg;
    logic signed [tws_pkg::S_W-1:0]    s8_reg;

    logic signed [tws_pkg::WP_W-1:0]   w_rnd;
    logic signed [tws_pkg::WP_W-1:0]   w_full;
    logic signed [tws_pkg::W_W-1:0]    w9_reg;
    logic signed [tws_pkg::S_W-1:0]    s9_reg;

    logic signed [tws_pkg::CFG_W:0]    wet_s;
    logic signed [tws_pkg::CFG_W:0]    dry_s;
    logic signed [tws_pkg::PW_W-1:0]   pw10_reg;
    logic signed [tws_pkg::PD_W-1:0]   pd10_reg;

    logic signed [tws_pkg::MIX_W-1:0]  mix_sum;
    logic signed [tws_pkg::MIX_W-1:0]  mix_full;
    logic signed [tws_pkg::S_W-1:0]    res_next;
    logic signed [tws_pkg::S_W-1:0]    res_reg;

    // Stage 5: align the channel values with the table read.
    always_ff @(posedge clk)
    begin
        if (en.p5)
        begin
            s5_reg    <= fr.s;
            m5_reg    <= fr.m;
            f5_reg    <= fr.f;
            over5_reg <= fr.over;
            neg5_reg  <= fr.neg;
        end
    end

    // Stage 6: one shared multiplier. Inside the curve it forms (b - a) * f on top of
    // a << 20; past the last entry it scales the magnitude by the last entry.
    assign diff      = {tbl_b[tws_pkg::T_W-1], tbl_b} - {tbl_a[tws_pkg::T_W-1], tbl_a};
    assign op1       = over5_reg ? {1'b0, m5_reg} : {1'b0, tws_pkg::M_W'(f5_reg)};
    assign op2       = over5_reg ? {tbl_b[tws_pkg::T_W-1], tbl_b} : diff;
    assign mprod_next = tws_pkg::X_W'(op1) * tws_pkg::X_W'(op2);
    assign madd_next  = over5_reg ? '0 : (tws_pkg::X_W'(tbl_a) <<< tws_pkg::FRAC_W);

    always_ff @(posedge clk)
    begin
        if (en.p6)
        begin
            mprod_reg <= mprod_next;
            madd_reg  <= madd_next;
            neg6_reg  <= neg5_reg;
            s6_reg    <= s5_reg;
        end
    end

    // Stage 7: round away the Q1.15 table scale and restore the input sign.
    assign x_rnd  = mprod_reg + madd_reg + tws_pkg::X_W'(tws_pkg::LVL_HALF);
    assign x_full = x_rnd >>> tws_pkg::LVL_SH;
    assign r      = x_full[tws_pkg::Y_W-1:0];
    assign y_next = neg6_reg ? -r : r;

    always_ff @(posedge clk)
    begin
        if (en.p7)
        begin
            y7_reg <= y_next;
            s7_reg <= s6_reg;
        end
    end

    // Stage 8: output gain.
    assign og_s    = $signed({1'b0, cfg.output_gain});
    assign wp_next = tws_pkg::WP_W'(y7_reg) * tws_pkg::WP_W'(og_s);

    always_ff @(posedge clk)
    begin
        if (en.p8)
        begin
            wp8_reg <= wp_next;
            s8_reg  <= s7_reg;
        end
    end

    // Stage 9: round the gained value.
    assign w_rnd  = wp8_reg + tws_pkg::WP_W'(tws_pkg::GAIN_HALF);
    assign w_full = w_rnd >>> tws_pkg::GAIN_SH;

    always_ff @(posedge clk)
    begin
        if (en.p9)
        begin
            w9_reg <= w_full[tws_pkg::W_W-1:0];
            s9_reg <= s8_reg;
        end
    end

    // Stage 10: wet and dry weights.
    assign wet_s = $signed({1'b0, cfg.wet_level});
    assign dry_s = $signed({1'b0, cfg.dry_level});

    always_ff @(posedge clk)
    begin
        if (en.p10)
        begin
            pw10_reg <= tws_pkg::PW_W'(w9_reg) * tws_pkg::PW_W'(wet_s);
            pd10_reg <= tws_pkg::PD_W'(s9_reg) * tws_pkg::PD_W'(dry_s);
        end
    end

    // Stage 11: sum, round and saturate to 24 bits.
    assign mix_sum  = tws_pkg::MIX_W'(pw10_reg) + tws_pkg::MIX_W'(pd10_reg)
                    + tws_pkg::MIX_W'(tws_pkg::LVL_HALF);
    assign mix_full = mix_sum >>> tws_pkg::LVL_SH;

    always_comb
    begin
        if (mix_full > tws_pkg::MIX_W'(tws_pkg::SAT_MAX))
        begin
            res_next = tws_pkg::S_W'(tws_pkg::SAT_MAX);
        end
        else if (mix_full < tws_pkg::MIX_W'(tws_pkg::SAT_MIN))
        begin
            res_next = tws_pkg::S_W'(tws_pkg::SAT_MIN);
        end
        else
        begin
            res_next = mix_full[tws_pkg::S_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.p11)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/core/table_waveshaper_stereo_unit.sv
// Stereo lookup-table waveshaper: top level with handshake control, curve memory and config.
// Depends on tws_pkg, tws_front and tws_back.
// Throughput: one request per clock cycle, frames and table writes alike, as long as the
// output side takes results; an empty stage anywhere lets a new request in under stall.
// Pipeline: a frame's result is registered through the eleven-stage multiply chain around
// the curve memory (stage five reads it) before it is presented on the output.
// Reset: configuration returns to unity gains, clip off, fully wet; the curve reads as zero
// through one valid bit per entry, so no clearing pass is needed and input is taken at once.
module table_waveshaper_stereo_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // Requests in. s_tdata, from bit 0: left_in[23:0], right_in[47:24],
    // entry_index[55:48], entry_value[71:56].
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [tws_pkg::IN_TDATA_W-1:0]        s_tdata,
    // s_tuser, from bit 0: operation (0 frame, 1 curve table write).
    input  logic                                  s_tuser,

    // Results out. m_tdata, from bit 0: left_out[23:0], right_out[47:24].
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [tws_pkg::OUT_TDATA_W-1:0]       m_tdata,

    // Configuration writes.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tws_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tws_pkg::CFG_W-1:0]             cfg_data
);

    tws_pkg::tws_cfg_t cfg_reg;
    tws_pkg::tws_en_t  en;

    // Stage valid flags; stage 11 is the output register.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;

    // Stage 1 payload and the table-write fields carried up to the memory stage.
    logic signed [tws_pkg::S_W-1:0]   in_l_reg;
    logic signed [tws_pkg::S_W-1:0]   in_r_reg;
    logic                             op1_reg, op2_reg, op3_reg, op4_reg;
    logic [tws_pkg::ENTRY_W-1:0]      eidx1_reg, eidx2_reg, eidx3_reg, eidx4_reg;
    logic [tws_pkg::T_W-1:0]          eval1_reg, eval2_reg, eval3_reg, eval4_reg;

    tws_pkg::tws_fr_t                 fr_l;
    tws_pkg::tws_fr_t                 fr_r;
    logic [tws_pkg::ADDR_W-1:0]       addr_l;
    logic [tws_pkg::ADDR_W-1:0]       addr_r;

    // The curve is kept twice: curve_b_mem[k] holds entry k and curve_a_mem[k] holds
    // entry k-1, so one address fetches both neighbors needed for interpolation.
    logic [tws_pkg::T_W-1:0]          curve_b_mem [tws_pkg::CURVE_POINTS];
    logic [tws_pkg::T_W-1:0]          curve_a_mem [tws_pkg::CURVE_POINTS];
    logic [tws_pkg::CURVE_POINTS-1:0] tbl_vld_reg;

    logic                             tbl_we;
    logic [tws_pkg::ADDR_W-1:0]       wr_addr;
    logic                             wr_has_next;

    logic [tws_pkg::T_W-1:0]          rd_a_l_reg, rd_b_l_reg, rd_a_r_reg, rd_b_r_reg;
    logic                             va_l_reg, vb_l_reg, va_r_reg, vb_r_reg;
    logic signed [tws_pkg::T_W-1:0]   tbl_a_l, tbl_b_l, tbl_a_r, tbl_b_r;

    logic signed [tws_pkg::S_W-1:0]   res_l;
    logic signed [tws_pkg::S_W-1:0]   res_r;

    // Configuration registers. The port never stalls; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_gain  <= 16'd4096;
            cfg_reg.output_gain <= 16'd4096;
            cfg_reg.clip_enable <= 1'b0;
            cfg_reg.wet_level   <= 16'd32768;
            cfg_reg.dry_level   <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tws_pkg::CFG_INPUT_GAIN:  cfg_reg.input_gain  <= cfg_data;
                tws_pkg::CFG_OUTPUT_GAIN: cfg_reg.output_gain <= cfg_data;
                tws_pkg::CFG_CLIP_ENABLE: cfg_reg.clip_enable <= cfg_data[0];
                tws_pkg::CFG_WET_LEVEL:   cfg_reg.wet_level   <= cfg_data;
                tws_pkg::CFG_DRY_LEVEL:   cfg_reg.dry_level   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline flow control. A stage loads when it is empty or when the stage after it
    // moves on, so bubbles are squeezed out and input keeps flowing while the output
    // register waits for the consumer, until every stage is full.
    assign en.p11 = !v11_reg || m_tready;
    assign en.p10 = !v10_reg || en.p11;
    assign en.p9  = !v9_reg  || en.p10;
    assign en.p8  = !v8_reg  || en.p9;
    assign en.p7  = !v7_reg  || en.p8;
    assign en.p6  = !v6_reg  || en.p7;
    assign en.p5  = !v5_reg  || en.p6;
    assign en.p4  = !v4_reg  || en.p5;
    assign en.p3  = !v3_reg  || en.p4;
    assign en.p2  = !v2_reg  || en.p3;
    assign en.p1  = !v1_reg  || en.p2;

    assign s_tready = en.p1;
    assign m_tvalid = v11_reg;

    // Table writes leave the pipeline at the memory stage; only frames go on to stage 5.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else
        begin
            if (en.p1)  v1_reg  <= s_tvalid;
            if (en.p2)  v2_reg  <= v1_reg;
            if (en.p3)  v3_reg  <= v2_reg;
            if (en.p4)  v4_reg  <= v3_reg;
            if (en.p5)  v5_reg  <= v4_reg && (op4_reg == tws_pkg::OP_FRAME);
            if (en.p6)  v6_reg  <= v5_reg;
            if (en.p7)  v7_reg  <= v6_reg;
            if (en.p8)  v8_reg  <= v7_reg;
            if (en.p9)  v9_reg  <= v8_reg;
            if (en.p10) v10_reg <= v9_reg;
            if (en.p11) v11_reg <= v10_reg;
        end
    end

    // Request payload and the write fields that ride along to the memory stage.
    always_ff @(posedge clk)
    begin
        if (en.p1)
        begin
            in_l_reg  <= s_tdata[23:0];
            in_r_reg  <= s_tdata[47:24];
            op1_reg   <= s_tuser;
            eidx1_reg <= s_tdata[55:48];
            eval1_reg <= s_tdata[71:56];
        end
        if (en.p2)
        begin
            op2_reg   <= op1_reg;
            eidx2_reg <= eidx1_reg;
            eval2_reg <= eval1_reg;
        end
        if (en.p3)
        begin
            op3_reg   <= op2_reg;
            eidx3_reg <= eidx2_reg;
            eval3_reg <= eval2_reg;
        end
        if (en.p4)
        begin
            op4_reg   <= op3_reg;
            eidx4_reg <= eidx3_reg;
            eval4_reg <= eval3_reg;
        end
    end

    // Gain, clip and address generation for each channel.
    tws_front u_front_l (
        .clk  (clk),
        .en   (en),
        .cfg  (cfg_reg),
        .s_in (in_l_reg),
        .fr   (fr_l),
        .addr (addr_l)
    );

    tws_front u_front_r (
        .clk  (clk),
        .en   (en),
        .cfg  (cfg_reg),
        .s_in (in_r_reg),
        .fr   (fr_r),
        .addr (addr_r)
    );

    // Memory stage. Writes and reads happen at the same pipeline position, so every
    // frame sees exactly the writes that were accepted before it and no forwarding is
    // needed. A write of entry k also updates the shifted copy at k+1; indexes past
    // the end of the curve are ignored.
    assign tbl_we      = en.p5 && v4_reg && (op4_reg == tws_pkg::OP_WRITE)
                         && (32'(eidx4_reg) < tws_pkg::CURVE_POINTS);
    assign wr_addr     = tws_pkg::ADDR_W'(eidx4_reg);
    assign wr_has_next = (wr_addr != tws_pkg::ADDR_W'(tws_pkg::CURVE_POINTS - 1));

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            curve_b_mem[wr_addr] <= eval4_reg;
            if (wr_has_next)
            begin
                curve_a_mem[wr_addr + tws_pkg::ADDR_W'(1)] <= eval4_reg;
            end
        end
        if (en.p5)
        begin
            rd_b_l_reg <= curve_b_mem[addr_l];
            rd_a_l_reg <= curve_a_mem[addr_l];
            rd_b_r_reg <= curve_b_mem[addr_r];
            rd_a_r_reg <= curve_a_mem[addr_r];
            // The left neighbor of entry 0 is the zero point of the curve.
            vb_l_reg   <= tbl_vld_reg[addr_l];
            va_l_reg   <= (addr_l != '0) && tbl_vld_reg[addr_l - tws_pkg::ADDR_W'(1)];
            vb_r_reg   <= tbl_vld_reg[addr_r];
            va_r_reg   <= (addr_r != '0) && tbl_vld_reg[addr_r - tws_pkg::ADDR_W'(1)];
        end
    end

    // An entry that was never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_vld_reg <= '0;
        end
        else if (tbl_we)
        begin
            tbl_vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign tbl_a_l = va_l_reg ? rd_a_l_reg : '0;
    assign tbl_b_l = vb_l_reg ? rd_b_l_reg : '0;
    assign tbl_a_r = va_r_reg ? rd_a_r_reg : '0;
    assign tbl_b_r = vb_r_reg ? rd_b_r_reg : '0;

    // Interpolation, output gain and mix for each channel.
    tws_back u_back_l (
        .clk   (clk),
        .en    (en),
        .cfg   (cfg_reg),
        .fr    (fr_l),
        .tbl_a (tbl_a_l),
        .tbl_b (tbl_b_l),
        .res   (res_l)
    );

    tws_back u_back_r (
        .clk   (clk),
        .en    (en),
        .cfg   (cfg_reg),
        .fr    (fr_r),
        .tbl_a (tbl_a_r),
        .tbl_b (tbl_b_r),
        .res   (res_r)
    );

    assign m_tdata = {res_r, res_l};

endmodule

>>> sim/testbench.sv
// Self-checking testbench of the stereo table waveshaper: directed and random requests,
// a scoreboard class that predicts each frame, and randomly paced stream handshakes.
// Depends on tws_pkg and table_waveshaper_stereo_unit only.
`timescale 1ns / 100ps

module testbench;

    localparam real CLK_PERIOD    = 2.0;
    localparam int  RESET_CYCLES  = 11;
    // Covers the pipeline from an accepted request to its result, plus margin for table writes
    // still in the pipe, which never show up on the output.
    localparam int  SETTLE_CYCLES = 16;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  REPORT_LIMIT  = 10;

    typedef enum int {PACE_FULL, PACE_RANDOM, PACE_SPARSE} pace_t;

    typedef struct {
        logic [tws_pkg::S_W-1:0] left;
        logic [tws_pkg::S_W-1:0] right;
    } stereo_pair_t;

    // Scoreboard: keeps its own copy of the curve and the registers, predicts the
    // result of each accepted frame and compares it with what the block returns.
    class waveshaper_scoreboard;
        logic signed [tws_pkg::T_W-1:0] curve [tws_pkg::CURVE_POINTS];
        logic [tws_pkg::CFG_W-1:0]      in_gain;
        logic [tws_pkg::CFG_W-1:0]      out_gain;
        logic                           clip_on;
        logic [tws_pkg::CFG_W-1:0]      wet;
        logic [tws_pkg::CFG_W-1:0]      dry;
        stereo_pair_t                   expected_frames [$];
        int                             mismatches;
        int                             frames_checked;
        int                             curve_writes;

        function new();
            foreach (curve[i])
                curve[i] = '0;
            in_gain        = 16'd4096;
            out_gain       = 16'd4096;
            clip_on        = 1'b0;
            wet            = 16'd32768;
            dry            = 16'd0;
            mismatches     = 0;
            frames_checked = 0;
            curve_writes   = 0;
        endfunction

        function void set_register(logic [tws_pkg::CFG_IDX_W-1:0] idx,
                                   logic [tws_pkg::CFG_W-1:0] value);
            case (idx)
                tws_pkg::CFG_INPUT_GAIN:  in_gain  = value;
                tws_pkg::CFG_OUTPUT_GAIN: out_gain = value;
                tws_pkg::CFG_CLIP_ENABLE: clip_on  = value[0];
                tws_pkg::CFG_WET_LEVEL:   wet      = value;
                tws_pkg::CFG_DRY_LEVEL:   dry      = value;
                default: ;
            endcase
        endfunction

        // Adds half an LSB and floors, which is round half up for either sign.
        function longint round_shift(longint x, int sh);
            return (x + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function logic [tws_pkg::S_W-1:0] shape_sample(logic signed [tws_pkg::S_W-1:0] x_in);
            longint s, g, m, p, idx, f, a, b, y, w, mix;
            longint one;
            one = longint'(1) << tws_pkg::FRAC_W;
            s   = longint'(x_in);
            g   = round_shift(s * longint'(in_gain), tws_pkg::GAIN_SH);
            if (clip_on)
            begin
                if (g > one)
                    g = one;
                if (g < -one)
                    g = -one;
            end
            m   = (g < 0) ? -g : g;
            p   = m * tws_pkg::CURVE_POINTS;
            idx = p >>> tws_pkg::FRAC_W;
            f   = p & (one - 1);
            // Below the first point the curve ramps up from zero; past the last point
            // the sample is scaled by the last entry instead of interpolated.
            if (idx == 0)
                y = round_shift(f * longint'(curve[0]), tws_pkg::LVL_SH);
            else if (idx < tws_pkg::CURVE_POINTS)
            begin
                a = longint'(curve[int'(idx) - 1]);
                b = longint'(curve[int'(idx)]);
                y = round_shift(a * one + (b - a) * f, tws_pkg::LVL_SH);
            end
            else
                y = round_shift(m * longint'(curve[tws_pkg::CURVE_POINTS - 1]),
                                tws_pkg::LVL_SH);
            if (g < 0)
                y = -y;
            w   = round_shift(y * longint'(out_gain), tws_pkg::GAIN_SH);
            mix = round_shift(longint'(dry) * s + longint'(wet) * w, tws_pkg::LVL_SH);
            if (mix > longint'(tws_pkg::SAT_MAX))
                mix = longint'(tws_pkg::SAT_MAX);
            if (mix < longint'(tws_pkg::SAT_MIN))
                mix = longint'(tws_pkg::SAT_MIN);
            return mix[tws_pkg::S_W-1:0];
        endfunction

        function void note_request(logic op, logic [tws_pkg::IN_TDATA_W-1:0] data);
            stereo_pair_t pair;
            if (op == tws_pkg::OP_WRITE)
            begin
                // Positions past the end of the curve are dropped by the block.
                if (data[55:48] < tws_pkg::CURVE_POINTS)
                begin
                    curve[data[55:48]] = data[71:56];
                    curve_writes++;
                end
            end
            else
            begin
                pair.left  = shape_sample(data[23:0]);
                pair.right = shape_sample(data[47:24]);
                expected_frames.push_back(pair);
            end
        endfunction

        function void report(string what, logic [tws_pkg::S_W-1:0] exp_v,
                             logic [tws_pkg::S_W-1:0] got_v);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%t: %s mismatch, expected %h, got %h", $time, what, exp_v, got_v);
        endfunction

        function void check_result(logic [tws_pkg::OUT_TDATA_W-1:0] data);
            stereo_pair_t pair;
            if (expected_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%t: result %h arrived with no frame outstanding", $time, data);
                return;
            end
            pair = expected_frames.pop_front();
            frames_checked++;
            if (data[23:0] !== pair.left)
                report("left_out", pair.left, data[23:0]);
            if (data[47:24] !== pair.right)
                report("right_out", pair.right, data[47:24]);
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             s_tvalid     = 1'b0;
    logic                             s_tready;
    logic [tws_pkg::IN_TDATA_W-1:0]   s_tdata      = '0;
    logic                             s_tuser      = tws_pkg::OP_FRAME;
    logic                             m_tvalid;
    logic                             m_tready     = 1'b0;
    logic [tws_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic                             cfg_valid    = 1'b0;
    logic                             cfg_ready;
    logic [tws_pkg::CFG_IDX_W-1:0]    cfg_index    = '0;
    logic [tws_pkg::CFG_W-1:0]        cfg_data     = '0;

    // Pacing of both stream sides, and the long output stall that backs up the pipe.
    pace_t                            tx_pace      = PACE_FULL;
    pace_t                            rx_pace      = PACE_FULL;
    logic                             hold_request = 1'b0;
    logic                             rx_blocked   = 1'b0;
    int                               rx_wait      = 0;
    int                               cycle_count  = 0;
    int                               config_phases = 0;

    waveshaper_scoreboard             sb;

    always #(CLK_PERIOD / 2) clk = ~clk;

    table_waveshaper_stereo_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Number of idle cycles before the next request or after a taken result.
    // Full pace never idles, sparse idles on about one item in four.
    function automatic int draw_wait(pace_t pace);
        case (pace)
            PACE_FULL:   return 0;
            PACE_RANDOM: return $urandom_range(0, 16);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
        endcase
    endfunction

    // Output side. Results are sampled at the edge where they are taken, so values
    // seen here are those from before the edge. After each result the receiver may
    // stall for a drawn number of cycles; the long hold-off overrides everything.
    always @(posedge clk)
    begin
        if (m_tvalid === 1'b1 && m_tready)
        begin
            sb.check_result(m_tdata);
            rx_wait = draw_wait(rx_pace);
        end
        if (rx_blocked)
            m_tready <= 1'b0;
        else if (rx_wait > 0)
        begin
            rx_wait = rx_wait - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Long hold-off of the output, counted here so the sender keeps pushing requests
    // meanwhile; the pipe fills and s_tready must drop until the output opens again.
    initial
    begin
        @(posedge hold_request);
        rx_blocked <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_blocked <= 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d frames outstanding",
                     cycle_count, sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offers one request and returns at the edge that accepts it. The valid stays high
    // into the next request unless a gap is drawn, so back-to-back requests are tested.
    task automatic send_request(input logic op, input logic [tws_pkg::IN_TDATA_W-1:0] data);
        int gap;
        gap = draw_wait(tx_pace);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(op, data);
    endtask

    // The fields that a request kind does not use are filled with random bits.
    task automatic send_frame(input logic [tws_pkg::S_W-1:0] left,
                              input logic [tws_pkg::S_W-1:0] right);
        send_request(tws_pkg::OP_FRAME, {16'($urandom), 8'($urandom), right, left});
    endtask

    task automatic send_entry(input logic [tws_pkg::ENTRY_W-1:0] idx,
                              input logic [tws_pkg::T_W-1:0] value);
        send_request(tws_pkg::OP_WRITE, {value, idx, 24'($urandom), 24'($urandom)});
    endtask

    task automatic write_register(input logic [tws_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [tws_pkg::CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] in_gain, input logic [15:0] out_gain,
                             input logic clip_on, input logic [15:0] wet,
                             input logic [15:0] dry);
        write_register(tws_pkg::CFG_INPUT_GAIN, in_gain);
        write_register(tws_pkg::CFG_OUTPUT_GAIN, out_gain);
        write_register(tws_pkg::CFG_CLIP_ENABLE, {15'd0, clip_on});
        write_register(tws_pkg::CFG_WET_LEVEL, wet);
        write_register(tws_pkg::CFG_DRY_LEVEL, dry);
        config_phases++;
    endtask

    // Lowers the request valid, waits for every outstanding frame, then lets any table
    // write still in flight retire before the registers may change.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sample mix: full range, the extremes, within one, right around one, the region
    // below the first curve point, and moderate overdrive; either sign.
    function automatic logic [tws_pkg::S_W-1:0] make_sample();
        logic [tws_pkg::S_W-1:0] mag;
        case ($urandom_range(0, 9))
            0, 1: return 24'($urandom);
            2:
            begin
                case ($urandom_range(0, 6))
                    0:       return 24'h7FFFFF;
                    1:       return 24'h800000;
                    2:       return 24'h000000;
                    3:       return 24'hFFFFFF;
                    4:       return 24'h100000;
                    5:       return 24'hF00000;
                    default: return 24'h000001;
                endcase
            end
            3, 4, 5: mag = 24'($urandom_range(0, 1 << 20));
            6:       mag = 24'((1 << 20) - 32 + $urandom_range(0, 64));
            7:       mag = 24'($urandom_range(0, 5300));
            default: mag = 24'($urandom_range(0, 1 << 22));
        endcase
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
    endfunction

    function automatic logic [tws_pkg::T_W-1:0] make_entry();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly frames; about one request in six rewrites the curve, and one write in
    // eight aims past its end.
    task automatic random_traffic(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_entry(8'($urandom_range(tws_pkg::CURVE_POINTS, 255)), make_entry());
                else
                    send_entry(8'($urandom_range(0, tws_pkg::CURVE_POINTS - 1)), make_entry());
            end
            else
                send_frame(make_sample(), make_sample());
        end
    endtask

    task automatic fill_curve();
        for (int i = 0; i < tws_pkg::CURVE_POINTS; i++)
            send_entry(8'(i), make_entry());
    endtask

    initial
    begin
        int errors;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings (unity gains, fully wet), back to back.
        // A frame against the cleared curve must give zero.
        tx_pace = PACE_FULL;
        rx_pace <= PACE_FULL;
        send_frame(24'h7FFFFF, 24'h800000);
        send_entry(8'd0, 16'h7FFF);
        send_entry(8'd199, 16'h8000);
        send_entry(8'd1, 16'h8000);
        send_entry(8'd99, 16'hC000);
        send_entry(8'd100, 16'h4000);
        // Writes past the end of the curve must leave it alone.
        send_entry(8'd200, 16'h3039);
        send_entry(8'd255, 16'h7FFF);
        send_frame(24'h000000, 24'hFFFFFF);
        // Just below and just at the first interpolated segment.
        send_frame(24'd5242, -24'd5243);
        send_frame(24'h001000, 24'hFFF000);
        // Exactly at point 100, then reading it right after a rewrite.
        send_frame(24'h080000, 24'hF80000);
        send_entry(8'd100, 16'h8000);
        send_frame(24'h080000, 24'hF80000);
        // Top segment, exactly one (beyond the last point) and the field extremes.
        send_frame(24'h0FFFFF, 24'hF00001);
        send_frame(24'h100000, 24'hF00000);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h000001, 24'h800001);

        tx_pace = PACE_SPARSE;
        rx_pace <= PACE_RANDOM;
        random_traffic(100);
        wait_idle();

        // Unity gains with clipping; a fresh random curve loaded as one run of writes at sparse pace.
        configure(16'd4096, 16'd4096, 1'b1, 16'd32768, 16'd0);
        fill_curve();
        tx_pace = PACE_RANDOM;
        random_traffic(100);
        wait_idle();

        // Gains and levels at their top value, clipping off, levels above one: heavy saturation.
        configure(16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF, 16'hFFFF);
        rx_pace <= PACE_SPARSE;
        random_traffic(100);
        wait_idle();

        // Gains and levels at zero, clipping on: all results must be zero.
        configure(16'd0, 16'd0, 1'b1, 16'd0, 16'd0);
        tx_pace = PACE_SPARSE;
        rx_pace <= PACE_RANDOM;
        random_traffic(60);
        wait_idle();

        // Half wet, half dry, with the output held off for a long stretch while
        // requests keep coming at full rate.
        configure(16'd8192, 16'd2048, 1'b1, 16'd16384, 16'd16384);
        tx_pace = PACE_FULL;
        rx_pace <= PACE_FULL;
        hold_request <= 1'b1;
        random_traffic(150);
        wait_idle();

        // Random settings, with the pacing of both sides varied from phase to phase.
        for (int ph = 0; ph < 4; ph++)
        begin
            configure(16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom),
                      16'($urandom));
            tx_pace = pace_t'($urandom_range(0, 2));
            rx_pace <= pace_t'($urandom_range(0, 2));
            random_traffic(50);
            wait_idle();
        end

        errors = sb.mismatches;
        if (sb.pending() != 0)
        begin
            $display("%0d expected results never arrived", sb.pending());
            errors += sb.pending();
        end
        $display("Run covered %0d frames and %0d curve writes over %0d register settings,",
                 sb.frames_checked, sb.curve_writes, config_phases + 1);
        $display("including clipping, saturation, levels above one and a long output stall.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> table_waveshaper_stereo_unit.f
rtl/core/tws_pkg.sv
rtl/core/tws_front.sv
rtl/core/tws_back.sv
rtl/core/table_waveshaper_stereo_unit.sv
sim/testbench.sv
